[hdl/sensor_record_deserializer_core_assert.svh]
// ---------------------------------------------------------------------------
// Sensor record deserializer assertion macros
// Shared property wrappers for the block's port checker.
// ---------------------------------------------------------------------------
`ifndef SENSOR_RECORD_DESERIALIZER_CORE_ASSERT_SVH
`define SENSOR_RECORD_DESERIALIZER_CORE_ASSERT_SVH

// Check a property outside reset.
`define SRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SRD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/srd_pkg.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer package
// Transfer types, record kind codes, sizes and the category search helper.
// ---------------------------------------------------------------------------
package srd_pkg;

  localparam int unsigned NCAT         = 7;
  localparam int unsigned SERIAL_BYTES = 12;   // 0 to 16
  localparam int unsigned TIME_BYTES   = 4;
  localparam int unsigned CNT_W        = 4;

  localparam logic [2:0] CAT_NONE = 3'd7;

  localparam logic [1:0] KIND_TIME   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } srd_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  category;
    logic [15:0] sample_value;
    logic [7:0]  sample_index;
    logic [31:0] timestamp_seconds;
    logic        end_of_message;
  } srd_out_t;

  // Lowest set bit of mask at or above from; CAT_NONE when there is none.
  function automatic logic [2:0] first_set(logic [NCAT-1:0] mask, logic [2:0] from);
    logic [2:0] res;
    res = CAT_NONE;
    for (int c = NCAT - 1; c >= 0; c--) begin
      if (mask[c] && (3'(c) >= from)) begin
        res = 3'(c);
      end
    end
    return res;
  endfunction

endpackage

[hdl/srd_in_stage.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer input stage
// Registers one incoming byte transfer and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module srd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srd_pkg::srd_in_t in_data_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output srd_pkg::srd_in_t item_o
);

  logic             valid_q, valid_d;
  srd_pkg::srd_in_t data_q;
  logic             accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

[hdl/srd_parser.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer parser
// Message state machine: header, counts, timestamp, serial skip and samples.
// ---------------------------------------------------------------------------
module srd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  srd_pkg::srd_in_t item_i,
  output logic             rec_valid_o,
  output srd_pkg::srd_out_t rec_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COUNTS  = 3'd1;
  localparam logic [2:0] PH_TIME    = 3'd2;
  localparam logic [2:0] PH_SERIAL  = 3'd3;
  localparam logic [2:0] PH_SAMPLES = 3'd4;

  localparam int unsigned NCAT  = srd_pkg::NCAT;
  localparam int unsigned CNT_W = srd_pkg::CNT_W;

  logic [2:0]       phase_q, phase_d;
  logic [NCAT-1:0]  mask_q, mask_d;
  logic [NCAT-1:0]  nz_q, nz_d;
  logic [7:0]       counts_q [NCAT];
  logic             cnt_we;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic [31:0]      time_q, time_d;
  logic [7:0]       hold_q, hold_d;
  logic [2:0]       cat_q, cat_d;
  logic [7:0]       done_q, done_d;
  logic             parity_q, parity_d;

  logic [NCAT-1:0]  hdr_mask;
  logic [2:0]       nxt;
  logic [CNT_W-1:0] pcnt_inc;
  logic [7:0]       done_inc;
  logic [7:0]       byte_in;

  assign byte_in  = item_i.data_byte;
  assign pcnt_inc = pcnt_q + 1'b1;
  assign done_inc = done_q + 8'd1;

  always_comb begin
    for (int k = 0; k < NCAT; k++) begin
      hdr_mask[k] = byte_in[7-k];
    end
  end

  always_comb begin
    phase_d  = phase_q;
    mask_d   = mask_q;
    nz_d     = nz_q;
    cnt_we   = 1'b0;
    pcnt_d   = pcnt_q;
    time_d   = time_q;
    hold_d   = hold_q;
    cat_d    = cat_q;
    done_d   = done_q;
    parity_d = parity_q;
    nxt      = srd_pkg::CAT_NONE;

    rec_valid_o              = 1'b0;
    rec_o.record_kind        = srd_pkg::KIND_TIME;
    rec_o.category           = 3'd0;
    rec_o.sample_value       = 16'd0;
    rec_o.sample_index       = 8'd0;
    rec_o.end_of_message     = 1'b0;

    if (item_i.start_of_message) begin
      // Restart the parse on a header byte.
      mask_d   = hdr_mask;
      nz_d     = '0;
      pcnt_d   = '0;
      time_d   = 32'd0;
      hold_d   = 8'd0;
      done_d   = 8'd0;
      parity_d = 1'b0;
      nxt      = srd_pkg::first_set(hdr_mask, 3'd0);
      if (nxt != srd_pkg::CAT_NONE) begin
        phase_d = PH_COUNTS;
        cat_d   = nxt;
      end else begin
        phase_d = PH_TIME;
        cat_d   = 3'd0;
      end
    end else begin
      case (phase_q)
        PH_COUNTS: begin
          cnt_we       = 1'b1;
          nz_d[cat_q]  = |byte_in;
          nxt          = srd_pkg::first_set(mask_q, cat_q + 3'd1);
          if (nxt != srd_pkg::CAT_NONE) begin
            cat_d = nxt;
          end else begin
            cat_d   = 3'd0;
            phase_d = PH_TIME;
          end
        end
        PH_TIME: begin
          time_d = {time_q[23:0], byte_in};
          if (pcnt_inc < CNT_W'(srd_pkg::TIME_BYTES)) begin
            pcnt_d = pcnt_inc;
          end else begin
            pcnt_d      = '0;
            rec_valid_o = 1'b1;
            nxt         = srd_pkg::first_set(nz_q, 3'd0);
            if (srd_pkg::SERIAL_BYTES > 0) begin
              phase_d = PH_SERIAL;
            end else if (nxt != srd_pkg::CAT_NONE) begin
              phase_d  = PH_SAMPLES;
              cat_d    = nxt;
              done_d   = 8'd0;
              parity_d = 1'b0;
            end else begin
              phase_d              = PH_IDLE;
              rec_o.end_of_message = 1'b1;
            end
          end
        end
        PH_SERIAL: begin
          if ({1'b0, pcnt_q} + 5'd1 < 5'(srd_pkg::SERIAL_BYTES)) begin
            pcnt_d = pcnt_inc;
          end else begin
            pcnt_d = '0;
            nxt    = srd_pkg::first_set(nz_q, 3'd0);
            if (nxt != srd_pkg::CAT_NONE) begin
              phase_d  = PH_SAMPLES;
              cat_d    = nxt;
              done_d   = 8'd0;
              parity_d = 1'b0;
            end else begin
              // Message without samples: close it with an end record.
              phase_d              = PH_IDLE;
              rec_valid_o          = 1'b1;
              rec_o.record_kind    = srd_pkg::KIND_END;
              rec_o.end_of_message = 1'b1;
            end
          end
        end
        PH_SAMPLES: begin
          if (!parity_q) begin
            hold_d   = byte_in;
            parity_d = 1'b1;
          end else begin
            parity_d           = 1'b0;
            rec_valid_o        = 1'b1;
            rec_o.record_kind  = srd_pkg::KIND_SAMPLE;
            rec_o.category     = cat_q;
            rec_o.sample_value = {hold_q, byte_in};
            rec_o.sample_index = done_q;
            done_d             = done_inc;
            if (done_inc >= counts_q[cat_q]) begin
              nxt = srd_pkg::first_set(nz_q, cat_q + 3'd1);
              if (nxt != srd_pkg::CAT_NONE) begin
                cat_d  = nxt;
                done_d = 8'd0;
              end else begin
                phase_d              = PH_IDLE;
                rec_o.end_of_message = 1'b1;
              end
            end
          end
        end
        default: begin
          // Drop bytes outside a message.
        end
      endcase
    end

    rec_o.timestamp_seconds = time_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      mask_q   <= '0;
      nz_q     <= '0;
      pcnt_q   <= '0;
      time_q   <= 32'd0;
      hold_q   <= 8'd0;
      cat_q    <= 3'd0;
      done_q   <= 8'd0;
      parity_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      mask_q   <= mask_d;
      nz_q     <= nz_d;
      pcnt_q   <= pcnt_d;
      time_q   <= time_d;
      hold_q   <= hold_d;
      cat_q    <= cat_d;
      done_q   <= done_d;
      parity_q <= parity_d;
    end
  end

  // Counts are read only where the nonzero mask marks them written.
  always_ff @(posedge clk_i) begin
    if (step_i && cnt_we) begin
      counts_q[cat_q] <= byte_in;
    end
  end

endmodule

[hdl/srd_out_stage.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer output stage
// Result register that holds a record until the receiving side takes it.
// ---------------------------------------------------------------------------
module srd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  srd_pkg::srd_out_t rec_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srd_pkg::srd_out_t out_data_o
);

  logic              valid_q, valid_d;
  srd_pkg::srd_out_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[hdl/sensor_record_deserializer_core.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer core
// Byte-stream parser for sensor-record messages.
// ---------------------------------------------------------------------------
// Takes one message byte per transfer and sustains one byte per clock while
// the output side does not stall. A byte is registered on acceptance and is
// parsed by the state machine when the result register can take its record.
// Any record it produces lands in the result register at the end of that
// cycle, so a record is offered only after its last byte has passed both the
// input register and the result register. A held result stalls parsing at
// once, and the input stalls as soon as the input register also holds a byte.
// ---------------------------------------------------------------------------
module sensor_record_deserializer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srd_pkg::srd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srd_pkg::srd_out_t out_data_o
);

  logic              item_valid;
  srd_pkg::srd_in_t  item;
  logic              out_free;
  logic              advance;
  logic              rec_valid;
  srd_pkg::srd_out_t rec;

  // Parse a byte only when the result register can take what it produces.
  assign advance = item_valid && out_free;

  srd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  srd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  srd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && rec_valid),
    .rec_i       (rec),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/srd_checker.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer port checker
// Watches the top level's ports for record and handshake consistency.
// ---------------------------------------------------------------------------
`include "sensor_record_deserializer_core_assert.svh"

module srd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input srd_pkg::srd_out_t out_data_o
);

  logic no_sample_fields;
  logic out_held;
  logic end_rec;
  logic other_rec;

  assign no_sample_fields = (out_data_o.category == 3'd0) &&
                            (out_data_o.sample_value == 16'd0) &&
                            (out_data_o.sample_index == 8'd0);

  assign out_held  = out_valid_o && out_stall_i;
  assign end_rec   = out_valid_o && (out_data_o.record_kind == srd_pkg::KIND_END);
  assign other_rec = out_valid_o && (out_data_o.record_kind != srd_pkg::KIND_SAMPLE);

  `SRD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (out_valid_o !== 1'b1), "result valid during reset")

  `SRD_ASSERT(a_stall_hold, out_held |=> out_valid_o && $stable(out_data_o),
              "stalled result changed")

  `SRD_ASSERT(a_end_closes, end_rec |-> out_data_o.end_of_message, "end record without end flag")

  `SRD_ASSERT(a_non_sample_clear, other_rec |-> no_sample_fields,
              "sample fields set on non-sample record")

  // The input backs up only behind a result the receiver holds off.
  `SRD_ASSERT(a_in_stall_cause, in_stall_o |-> out_held, "input stalled without a held result")

endmodule

bind sensor_record_deserializer_core srd_checker u_srd_checker (.*);

[test/sensor_record_deserializer_checker.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer checker
// Watches both channels, predicts every record from the accepted bytes and
// compares each delivered record with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module sensor_record_deserializer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  srd_pkg::srd_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  srd_pkg::srd_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       records_pending_o
);

  localparam int unsigned NCAT = srd_pkg::NCAT;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COUNTS  = 3'd1;
  localparam logic [2:0] PH_TIME    = 3'd2;
  localparam logic [2:0] PH_SERIAL  = 3'd3;
  localparam logic [2:0] PH_SAMPLES = 3'd4;

  logic [2:0]      state;
  logic [NCAT-1:0] present;
  logic [7:0]      count_of [NCAT];
  logic [3:0]      phase_bytes;
  logic [31:0]     stamp;
  logic [7:0]      high_half;
  logic [2:0]      cur_cat;
  logic [7:0]      cat_samples;
  logic            want_low;

  srd_pkg::srd_out_t record_q [$];
  int unsigned       mismatches;

  assign fail_count_o = mismatches;

  function automatic int next_present(int from);
    for (int c = from; c < int'(NCAT); c++) begin
      if (present[c]) return c;
    end
    return int'(NCAT);
  endfunction

  function automatic int next_nonzero(int from);
    for (int c = from; c < int'(NCAT); c++) begin
      if (count_of[c] != 8'd0) return c;
    end
    return int'(NCAT);
  endfunction

  task automatic clear_parser();
    state       = PH_IDLE;
    present     = '0;
    phase_bytes = '0;
    stamp       = '0;
    high_half   = '0;
    cur_cat     = '0;
    cat_samples = '0;
    want_low    = 1'b0;
    for (int k = 0; k < int'(NCAT); k++) count_of[k] = 8'd0;
  endtask

  task automatic start_samples(input int first);
    state       = PH_SAMPLES;
    cur_cat     = 3'(first);
    cat_samples = '0;
    want_low    = 1'b0;
  endtask

  // Advance the parser by one byte and queue the record it yields, if any.
  task automatic parse_byte(input srd_pkg::srd_in_t b);
    srd_pkg::srd_out_t rec;
    logic              produced;
    int                nxt;
    rec      = '0;
    produced = 1'b0;
    if (b.start_of_message) begin
      clear_parser();
      for (int k = 0; k < int'(NCAT); k++) present[k] = b.data_byte[7-k];
      nxt = next_present(0);
      if (nxt < int'(NCAT)) begin
        state   = PH_COUNTS;
        cur_cat = 3'(nxt);
      end else begin
        state = PH_TIME;
      end
    end else begin
      case (state)
        PH_COUNTS: begin
          count_of[cur_cat] = b.data_byte;
          nxt = next_present(int'(cur_cat) + 1);
          if (nxt < int'(NCAT)) begin
            cur_cat = 3'(nxt);
          end else begin
            cur_cat = '0;
            state   = PH_TIME;
          end
        end
        PH_TIME: begin
          stamp       = {stamp[23:0], b.data_byte};
          phase_bytes = phase_bytes + 4'd1;
          if (phase_bytes >= 4'(srd_pkg::TIME_BYTES)) begin
            phase_bytes     = '0;
            nxt             = next_nonzero(0);
            produced        = 1'b1;
            rec.record_kind = srd_pkg::KIND_TIME;
            if (srd_pkg::SERIAL_BYTES > 0) begin
              state = PH_SERIAL;
            end else if (nxt < int'(NCAT)) begin
              start_samples(nxt);
            end else begin
              state              = PH_IDLE;
              rec.end_of_message = 1'b1;
            end
          end
        end
        PH_SERIAL: begin
          if (int'(phase_bytes) + 1 < int'(srd_pkg::SERIAL_BYTES)) begin
            phase_bytes = phase_bytes + 4'd1;
          end else begin
            phase_bytes = '0;
            nxt = next_nonzero(0);
            if (nxt < int'(NCAT)) begin
              start_samples(nxt);
            end else begin
              state              = PH_IDLE;
              produced           = 1'b1;
              rec.record_kind    = srd_pkg::KIND_END;
              rec.end_of_message = 1'b1;
            end
          end
        end
        PH_SAMPLES: begin
          if (!want_low) begin
            high_half = b.data_byte;
            want_low  = 1'b1;
          end else begin
            want_low         = 1'b0;
            produced         = 1'b1;
            rec.record_kind  = srd_pkg::KIND_SAMPLE;
            rec.category     = cur_cat;
            rec.sample_value = {high_half, b.data_byte};
            rec.sample_index = cat_samples;
            cat_samples      = cat_samples + 8'd1;
            if (cat_samples >= count_of[cur_cat]) begin
              nxt = next_nonzero(int'(cur_cat) + 1);
              if (nxt < int'(NCAT)) begin
                cur_cat     = 3'(nxt);
                cat_samples = '0;
              end else begin
                state              = PH_IDLE;
                rec.end_of_message = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (produced) begin
      rec.timestamp_seconds = stamp;
      record_q = {record_q, rec};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_record(input srd_pkg::srd_out_t got);
    srd_pkg::srd_out_t want;
    if (record_q.size() == 0) begin
      $display("%0t: unexpected record, expected none, actual kind %0d value 0x%0h",
               $time, got.record_kind, got.sample_value);
      mismatches++;
    end else begin
      want = record_q.pop_front();
      check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
      check_field("category", 32'(want.category), 32'(got.category));
      check_field("sample_value", 32'(want.sample_value), 32'(got.sample_value));
      check_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
      check_field("timestamp_seconds", want.timestamp_seconds, got.timestamp_seconds);
      check_field("end_of_message", 32'(want.end_of_message), 32'(got.end_of_message));
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      record_q.delete();
      records_pending_o <= '0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_record(out_data_i);
      records_pending_o <= unsigned'(record_q.size());
    end
  end

endmodule

[test/sensor_record_deserializer_core_test.sv]
// ---------------------------------------------------------------------------
// Sensor record deserializer testbench
// Feeds directed and random sensor-record messages byte by byte, with random
// gaps and stalls on both channels, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module sensor_record_deserializer_core_test;

  localparam int unsigned NCAT         = srd_pkg::NCAT;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_BYTES = 1000;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  srd_pkg::srd_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  srd_pkg::srd_out_t out_data;

  int unsigned fail_count;
  int unsigned records_pending;
  int unsigned cycle_cnt  = 0;
  int unsigned bytes_sent = 0;
  logic        noisy      = 1'b1;
  logic        hold_token = 1'b0;
  logic        hold_seen  = 1'b0;
  logic [7:0]  msg_bytes [$];

  sensor_record_deserializer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sensor_record_deserializer_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .records_pending_o (records_pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall <= noisy && ($urandom_range(99) < 22);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic som);
    while (noisy && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, start_of_message: som};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send the first len bytes of the built message; the header carries the start flag.
  task automatic send_msg(input int unsigned len);
    foreach (msg_bytes[i]) begin
      if (i < len) send_byte(msg_bytes[i], i == 0);
    end
  endtask

  task automatic build_msg(input logic [7:0] hdr, input logic [NCAT-1:0][7:0] cnt,
                           input logic [31:0] stamp);
    msg_bytes.delete();
    msg_bytes = {msg_bytes, hdr};
    for (int k = 0; k < NCAT; k++) begin
      if (hdr[7-k]) msg_bytes = {msg_bytes, cnt[k]};
    end
    for (int k = 3; k >= 0; k--) msg_bytes = {msg_bytes, stamp[8*k +: 8]};
    repeat (srd_pkg::SERIAL_BYTES) msg_bytes = {msg_bytes, 8'($urandom)};
    for (int k = 0; k < NCAT; k++) begin
      if (hdr[7-k]) repeat (2 * cnt[k]) msg_bytes = {msg_bytes, 8'($urandom)};
    end
  endtask

  initial begin
    logic [NCAT-1:0][7:0] cnt;
    logic [7:0]           hdr;
    int unsigned          rand_start;
    int unsigned          msg_no;
    int unsigned          pick;
    int unsigned          sz;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray byte while idle: dropped.
    send_byte(8'hA5, 1'b0);

    // Only header bit zero set: no categories, timestamp then end record.
    build_msg(8'h01, '0, 32'h0000_0000);
    send_msg(msg_bytes.size());

    // All categories present, some counts zero, sample extremes.
    cnt = '0;
    cnt[0] = 8'd2;
    cnt[2] = 8'd1;
    cnt[6] = 8'd1;
    build_msg(8'hFE, cnt, 32'hFFFF_FFFF);
    sz = msg_bytes.size();
    msg_bytes[sz-8] = 8'hFF;
    msg_bytes[sz-7] = 8'hFF;
    msg_bytes[sz-6] = 8'h00;
    msg_bytes[sz-5] = 8'h00;
    send_msg(sz);

    // Present category with zero count; stray byte after the end.
    cnt = '0;
    build_msg(8'h80, cnt, 32'h8000_0001);
    send_msg(msg_bytes.size());
    send_byte(8'h3C, 1'b0);

    // Restarts: in the serial bytes, in the counts, between sample bytes.
    cnt = '0;
    cnt[1] = 8'd3;
    build_msg(8'h40, cnt, 32'h1234_5678);
    send_msg(10);
    cnt = '1;
    build_msg(8'hFF, cnt, 32'h0);
    send_msg(3);
    cnt = '0;
    cnt[6] = 8'd2;
    build_msg(8'h02, cnt, 32'hCAFE_0001);
    send_msg(msg_bytes.size() - 1);

    // Random messages: mostly well formed, some cut short, some trailed by noise.
    rand_start = bytes_sent;
    msg_no     = 0;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      noisy <= !(msg_no >= 5 && msg_no <= 9);
      if (msg_no == 2) hold_token <= ~hold_token;
      hdr = ($urandom_range(7) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
      for (int k = 0; k < NCAT; k++) begin
        pick = $urandom_range(99);
        if (pick < 25)      cnt[k] = 8'd0;
        else if (pick < 90) cnt[k] = 8'($urandom_range(1, 3));
        else                cnt[k] = 8'($urandom_range(4, 12));
      end
      if (msg_no == 11) begin
        pick        = $urandom_range(NCAT - 1);
        hdr[7-pick] = 1'b1;
        cnt[pick]   = 8'd255;
      end
      build_msg(hdr, cnt, $urandom);
      pick = $urandom_range(99);
      if (pick < 80 || msg_no == 11) begin
        send_msg(msg_bytes.size());
      end else if (pick < 92) begin
        send_msg($urandom_range(1, msg_bytes.size() - 1));
      end else begin
        send_msg(msg_bytes.size());
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
      msg_no++;
    end
    in_valid <= 1'b0;

    while (records_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
